FILE: hw/rtl/osdm_pkg.sv
// Shared constants, codes and types for the ordered store with delete-minimum.
// Used by osdm_cell and ordered_store_delete_min.
`timescale 1ns / 1ps
`default_nettype none

package osdm_pkg;

  localparam int STORE_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int STEP_W      = $clog2(STORE_DEPTH);

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_DISPLAY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [2:0] CELL_HOLD    = 3'd0;
  localparam logic [2:0] CELL_APPEND  = 3'd1;
  localparam logic [2:0] CELL_ROTATE  = 3'd2;
  localparam logic [2:0] CELL_MARK    = 3'd3;
  localparam logic [2:0] CELL_COMPACT = 3'd4;

  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] val;
    logic [COUNT_W-1:0]       cnt;
  } run_t;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] din;
    logic signed [DATA_W-1:0] min;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/osdm_cell.sv
// One storage cell of the ordered store: an entry, its valid bit, and one
// stage of the running minimum/tally chain. Depends on osdm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module osdm_cell import osdm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  cell_ctrl_t               ctrl,
  input  logic                     left_valid,
  input  logic                     hole_in,
  input  logic signed [DATA_W-1:0] right_value,
  input  logic                     right_valid,
  input  run_t                     run_in,
  output logic signed [DATA_W-1:0] value,
  output logic                     valid,
  output logic                     hole_out,
  output run_t                     run_out
);

  logic take_right;

  assign hole_out   = hole_in | ~valid;
  assign take_right = (ctrl.op == CELL_ROTATE) || ((ctrl.op == CELL_COMPACT) && hole_out);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_APPEND: begin
          if (!valid && left_valid) valid <= 1'b1;
        end
        CELL_ROTATE: valid <= right_valid;
        CELL_MARK: begin
          if (valid && (value == ctrl.min)) valid <= 1'b0;
        end
        CELL_COMPACT: begin
          if (hole_out) valid <= right_valid;
        end
        default: valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == CELL_APPEND && !valid && left_valid) begin
      value <= ctrl.din;
    end else if (take_right) begin
      value <= right_value;
    end
  end

  // min and count of entries equal to it, carried one cell per cycle
  always_ff @(posedge clk) begin
    if (!valid) begin
      run_out <= run_in;
    end else if (!run_in.valid || (value < run_in.val)) begin
      run_out <= '{valid: 1'b1, val: value, cnt: COUNT_W'(1)};
    end else if (value == run_in.val) begin
      run_out <= '{valid: 1'b1, val: run_in.val, cnt: run_in.cnt + COUNT_W'(1)};
    end else begin
      run_out <= run_in;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ordered_store_delete_min.sv
// Top level of the ordered store: controller plus a row of osdm_cell.
// Depends on osdm_pkg and osdm_cell.
`timescale 1ns / 1ps
`default_nettype none
//
// Usage: an item (operation, value) is taken on a rising edge with start high
// and busy low. Each result shows for one cycle with done high, together with
// status, data, removed_count and last; the receiver cannot stall it.
// Add: its result appears the cycle after the item is taken, and a new item
// may follow at once.
// Delete of a nonempty store: busy while the minimum and its tally ripple
// through the cell row (S_SCAN), the matches are marked (S_MARK), and the
// survivors shift left (S_PACK).
// Display of a nonempty store: the row rotates once around (S_SHOW); entries
// come out in order from the first, and the final one has last.
// Delete or display of an empty store: one result the next cycle.
// Unused operation codes are dropped with no result.
// Reset (rst, synchronous) empties the store and returns to idle.

module ordered_store_delete_min import osdm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                operation,
  input  logic signed [DATA_W-1:0]  value,
  output logic                      done,
  output logic [1:0]                status,
  output logic signed [DATA_W-1:0]  data,
  output logic [COUNT_W-1:0]        removed_count,
  output logic                      last
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MARK = 3'd2;
  localparam logic [2:0] S_PACK = 3'd3;
  localparam logic [2:0] S_SHOW = 3'd4;

  localparam logic [STEP_W-1:0] STEP_END = STEP_W'(STORE_DEPTH - 1);

  logic [2:0]          state;
  logic [STEP_W-1:0]   step;
  logic [COUNT_W-1:0]  entry_count;
  logic                accept;
  cell_ctrl_t          ctrl;

  logic signed [DATA_W-1:0] cell_value [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]   cell_valid;
  logic [STORE_DEPTH-1:0]   cell_hole;
  logic [STORE_DEPTH-1:0]   prev_valid;
  logic [STORE_DEPTH-1:0]   hole_chain;
  logic signed [DATA_W-1:0] right_value [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]   right_valid;
  run_t                     run_in  [STORE_DEPTH];
  run_t                     run_out [STORE_DEPTH];
  run_t                     tail_run;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign tail_run = run_out[STORE_DEPTH-1];

  always_comb begin
    ctrl.op  = CELL_HOLD;
    ctrl.din = value;
    ctrl.min = tail_run.val;
    case (state)
      S_IDLE: begin
        if (accept && (operation == OP_ADD) && (entry_count != COUNT_W'(STORE_DEPTH)))
          ctrl.op = CELL_APPEND;
      end
      S_MARK: ctrl.op = CELL_MARK;
      S_PACK: ctrl.op = CELL_COMPACT;
      S_SHOW: ctrl.op = CELL_ROTATE;
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < STORE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign prev_valid[gi] = 1'b1;
        assign hole_chain[gi] = 1'b0;
        assign run_in[gi]     = '{valid: 1'b0, val: '0, cnt: '0};
      end else begin : g_body
        assign prev_valid[gi] = cell_valid[gi-1];
        assign hole_chain[gi] = cell_hole[gi-1];
        assign run_in[gi]     = run_out[gi-1];
      end
      if (gi == STORE_DEPTH - 1) begin : g_tail
        assign right_value[gi] = cell_value[0];
        assign right_valid[gi] = (ctrl.op == CELL_ROTATE) ? cell_valid[0] : 1'b0;
      end else begin : g_inner
        assign right_value[gi] = cell_value[gi+1];
        assign right_valid[gi] = cell_valid[gi+1];
      end

      osdm_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .left_valid  (prev_valid[gi]),
        .hole_in     (hole_chain[gi]),
        .right_value (right_value[gi]),
        .right_valid (right_valid[gi]),
        .run_in      (run_in[gi]),
        .value       (cell_value[gi]),
        .valid       (cell_valid[gi]),
        .hole_out    (cell_hole[gi]),
        .run_out     (run_out[gi])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step        <= '0;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (operation)
              OP_ADD: begin
                done          <= 1'b1;
                data          <= '0;
                removed_count <= '0;
                last          <= 1'b1;
                if (entry_count == COUNT_W'(STORE_DEPTH)) begin
                  status <= ST_FULL;
                end else begin
                  status      <= ST_OK;
                  entry_count <= entry_count + COUNT_W'(1);
                end
              end
              OP_DELETE, OP_DISPLAY: begin
                if (entry_count == '0) begin
                  done          <= 1'b1;
                  status        <= ST_EMPTY;
                  data          <= '0;
                  removed_count <= '0;
                  last          <= 1'b1;
                end else begin
                  step  <= '0;
                  state <= (operation == OP_DELETE) ? S_SCAN : S_SHOW;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          step <= step + STEP_W'(1);
          if (step == STEP_END) state <= S_MARK;
        end
        S_MARK: begin
          data          <= tail_run.val;
          removed_count <= tail_run.cnt;
          entry_count   <= entry_count - tail_run.cnt;
          step          <= '0;
          state         <= S_PACK;
        end
        S_PACK: begin
          step <= step + STEP_W'(1);
          if (step == STEP_END) begin
            done   <= 1'b1;
            status <= ST_OK;
            last   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_SHOW: begin
          if (COUNT_W'(step) < entry_count) begin
            done          <= 1'b1;
            status        <= ST_OK;
            data          <= cell_value[0];
            removed_count <= '0;
            last          <= ((COUNT_W'(step) + COUNT_W'(1)) == entry_count);
          end
          step <= step + STEP_W'(1);
          if (step == STEP_END) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_prefix_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ($countones(cell_valid) == int'(entry_count)))
    else $error("valid bits do not match entry count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_W'(STORE_DEPTH))
    else $error("entry count above depth");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (entry_count != '0))
    else $error("delete scan on empty store");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_ADD) && (entry_count != COUNT_W'(STORE_DEPTH)))
    |=> (entry_count == $past(entry_count) + COUNT_W'(1)))
    else $error("add did not grow the store");
`endif

endmodule

`default_nettype wire
